### hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### hw/rtl/x86enc_pkg.sv
// types, constants and encoding form table for the mov/add/sub/ret encoder
// no dependencies
package x86enc_pkg;

    localparam int FORM_COUNT = 28;
    localparam int FORM_IDX_W = $clog2(FORM_COUNT);

    localparam logic [1:0] CMD_MOV = 2'd0;
    localparam logic [1:0] CMD_ADD = 2'd1;
    localparam logic [1:0] CMD_SUB = 2'd2;
    localparam logic [1:0] CMD_RET = 2'd3;

    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_REG  = 2'd1;
    localparam logic [1:0] K_MEM  = 2'd2;
    localparam logic [1:0] K_IMM  = 2'd3;

    localparam logic [2:0] SZ_NONE  = 3'd0;
    localparam logic [2:0] SZ_BYTE  = 3'd1;
    localparam logic [2:0] SZ_WORD  = 3'd2;
    localparam logic [2:0] SZ_DWORD = 3'd3;
    localparam logic [2:0] SZ_QWORD = 3'd4;

    localparam logic [1:0] T_PLAIN = 2'd0;
    localparam logic [1:0] T_EXT   = 2'd1;
    localparam logic [1:0] T_PLUS  = 2'd2;

    localparam logic [7:0] REX_W = 8'h48;
    localparam logic [7:0] REX_R = 8'h44;
    localparam logic [7:0] REX_B = 8'h41;

    localparam logic [7:0] OP_MOV_RM8_R8  = 8'h88;
    localparam logic [7:0] OP_MOV_RM_R    = 8'h89;
    localparam logic [7:0] OP_MOV_R8_RM8  = 8'h8a;
    localparam logic [7:0] OP_MOV_R_RM    = 8'h8b;
    localparam logic [7:0] OP_MOV_R8_IMM  = 8'hb0;
    localparam logic [7:0] OP_MOV_R_IMM   = 8'hb8;
    localparam logic [7:0] OP_MOV_RM8_IMM = 8'hc6;
    localparam logic [7:0] OP_MOV_RM_IMM  = 8'hc7;
    localparam logic [7:0] OP_ARITH_IMM8  = 8'h83;
    localparam logic [7:0] OP_RET         = 8'hc3;

    localparam logic [2:0] EXT_NONE = 3'd0;
    localparam logic [2:0] EXT_SUB  = 3'd5;

    localparam logic [1:0] MOD_INDIRECT = 2'b00;
    localparam logic [1:0] MOD_DIRECT   = 2'b11;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] opcode;
        logic [1:0] ftype;
        logic [2:0] ext;
        logic [1:0] kind0;
        logic [1:0] kind1;
        logic [2:0] size0;
        logic [2:0] size1;
        logic       has_modrm;
        logic       reg_is_dest;
        logic       rex_w;
    } form_t;

    localparam form_t FORMS [FORM_COUNT] = '{
        '{CMD_MOV, OP_MOV_RM8_R8,  T_PLAIN, EXT_NONE, K_REG, K_REG, SZ_BYTE,  SZ_BYTE,  1'b1, 1'b0, 1'b0},
        '{CMD_MOV, OP_MOV_RM8_R8,  T_PLAIN, EXT_NONE, K_MEM, K_REG, SZ_BYTE,  SZ_BYTE,  1'b1, 1'b0, 1'b0},
        '{CMD_MOV, OP_MOV_RM_R,    T_PLAIN, EXT_NONE, K_REG, K_REG, SZ_DWORD, SZ_DWORD, 1'b1, 1'b0, 1'b0},
        '{CMD_MOV, OP_MOV_RM_R,    T_PLAIN, EXT_NONE, K_MEM, K_REG, SZ_DWORD, SZ_DWORD, 1'b1, 1'b0, 1'b0},
        '{CMD_MOV, OP_MOV_RM_R,    T_PLAIN, EXT_NONE, K_REG, K_REG, SZ_QWORD, SZ_QWORD, 1'b1, 1'b0, 1'b1},
        '{CMD_MOV, OP_MOV_RM_R,    T_PLAIN, EXT_NONE, K_MEM, K_REG, SZ_QWORD, SZ_QWORD, 1'b1, 1'b0, 1'b1},
        '{CMD_MOV, OP_MOV_R8_RM8,  T_PLAIN, EXT_NONE, K_REG, K_REG, SZ_BYTE,  SZ_BYTE,  1'b1, 1'b1, 1'b0},
        '{CMD_MOV, OP_MOV_R8_RM8,  T_PLAIN, EXT_NONE, K_REG, K_MEM, SZ_BYTE,  SZ_BYTE,  1'b1, 1'b1, 1'b0},
        '{CMD_MOV, OP_MOV_R_RM,    T_PLAIN, EXT_NONE, K_REG, K_REG, SZ_DWORD, SZ_DWORD, 1'b1, 1'b1, 1'b0},
        '{CMD_MOV, OP_MOV_R_RM,    T_PLAIN, EXT_NONE, K_REG, K_MEM, SZ_DWORD, SZ_DWORD, 1'b1, 1'b1, 1'b0},
        '{CMD_MOV, OP_MOV_R_RM,    T_PLAIN, EXT_NONE, K_REG, K_REG, SZ_QWORD, SZ_QWORD, 1'b1, 1'b1, 1'b1},
        '{CMD_MOV, OP_MOV_R_RM,    T_PLAIN, EXT_NONE, K_REG, K_MEM, SZ_QWORD, SZ_QWORD, 1'b1, 1'b1, 1'b1},
        '{CMD_MOV, OP_MOV_R8_IMM,  T_PLUS,  EXT_NONE, K_REG, K_IMM, SZ_BYTE,  SZ_BYTE,  1'b0, 1'b0, 1'b0},
        '{CMD_MOV, OP_MOV_R_IMM,   T_PLUS,  EXT_NONE, K_REG, K_IMM, SZ_DWORD, SZ_DWORD, 1'b0, 1'b0, 1'b0},
        '{CMD_MOV, OP_MOV_R_IMM,   T_PLUS,  EXT_NONE, K_REG, K_IMM, SZ_QWORD, SZ_QWORD, 1'b0, 1'b0, 1'b1},
        '{CMD_MOV, OP_MOV_RM8_IMM, T_EXT,   EXT_NONE, K_MEM, K_IMM, SZ_BYTE,  SZ_BYTE,  1'b1, 1'b0, 1'b0},
        '{CMD_MOV, OP_MOV_RM_IMM,  T_EXT,   EXT_NONE, K_MEM, K_IMM, SZ_DWORD, SZ_DWORD, 1'b1, 1'b0, 1'b0},
        '{CMD_MOV, OP_MOV_RM_IMM,  T_EXT,   EXT_NONE, K_REG, K_IMM, SZ_QWORD, SZ_DWORD, 1'b1, 1'b0, 1'b1},
        '{CMD_MOV, OP_MOV_RM_IMM,  T_EXT,   EXT_NONE, K_MEM, K_IMM, SZ_QWORD, SZ_DWORD, 1'b1, 1'b0, 1'b1},
        '{CMD_ADD, OP_ARITH_IMM8,  T_EXT,   EXT_NONE, K_REG, K_IMM, SZ_DWORD, SZ_BYTE,  1'b1, 1'b0, 1'b0},
        '{CMD_ADD, OP_ARITH_IMM8,  T_EXT,   EXT_NONE, K_MEM, K_IMM, SZ_DWORD, SZ_BYTE,  1'b1, 1'b0, 1'b0},
        '{CMD_ADD, OP_ARITH_IMM8,  T_EXT,   EXT_NONE, K_REG, K_IMM, SZ_QWORD, SZ_BYTE,  1'b1, 1'b0, 1'b1},
        '{CMD_ADD, OP_ARITH_IMM8,  T_EXT,   EXT_NONE, K_MEM, K_IMM, SZ_QWORD, SZ_BYTE,  1'b1, 1'b0, 1'b1},
        '{CMD_SUB, OP_ARITH_IMM8,  T_EXT,   EXT_SUB,  K_REG, K_IMM, SZ_DWORD, SZ_BYTE,  1'b1, 1'b0, 1'b0},
        '{CMD_SUB, OP_ARITH_IMM8,  T_EXT,   EXT_SUB,  K_MEM, K_IMM, SZ_DWORD, SZ_BYTE,  1'b1, 1'b0, 1'b0},
        '{CMD_SUB, OP_ARITH_IMM8,  T_EXT,   EXT_SUB,  K_REG, K_IMM, SZ_QWORD, SZ_BYTE,  1'b1, 1'b0, 1'b1},
        '{CMD_SUB, OP_ARITH_IMM8,  T_EXT,   EXT_SUB,  K_MEM, K_IMM, SZ_QWORD, SZ_BYTE,  1'b1, 1'b0, 1'b1},
        '{CMD_RET, OP_RET,         T_PLAIN, EXT_NONE, K_NONE, K_NONE, SZ_NONE, SZ_NONE, 1'b0, 1'b0, 1'b0}
    };

    // one classified instruction, as handed from front end to back end
    typedef struct packed {
        logic        no_match;
        logic        has_rex;
        logic [7:0]  rex;
        logic [7:0]  opcode;
        logic        has_modrm;
        logic [7:0]  modrm;
        logic        has_imm;
        logic [2:0]  imm_last;
        logic [63:0] imm;
    } desc_t;

    typedef enum logic [3:0] {
        PH_PREFIX = 4'b0001,
        PH_OPCODE = 4'b0010,
        PH_MODRM  = 4'b0100,
        PH_IMM    = 4'b1000
    } phase_t;

endpackage

### hw/rtl/x86_64_mov_add_sub_encoder.sv
// top level of the mov/add/sub/ret machine code encoder
// depends on x86enc_pkg, x86enc_front, x86enc_queue, x86enc_back
//
// One instruction is taken per push transfer and classified combinationally against
// the 28-entry form table; its encoding waits in a QUEUE_DEPTH-entry queue. The back end
// hands out one code byte per pop transfer: REX prefix if any, opcode, ModRM if the
// form has one, then 1, 2, 4 or 8 immediate bytes, so an instruction gives 1 to 10 bytes
// and last_byte marks its final byte. Bytes of one instruction follow each other with no
// gap while pop stays high. An instruction with no matching form gives one byte 0x00 with
// no_match and last_byte set. Memory operands are encoded with mod 00 and no SIB or
// displacement byte.
module x86_64_mov_add_sub_encoder
    import x86enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [1:0]  dest_kind,
    input  logic [3:0]  dest_reg,
    input  logic [2:0]  dest_size,
    input  logic [1:0]  src_kind,
    input  logic [3:0]  src_reg,
    input  logic [2:0]  src_size,
    input  logic [63:0] immediate,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  code_byte,
    output logic        last_byte,
    output logic        no_match
);

    desc_t front_desc;
    desc_t head_desc;
    logic  head_valid;
    logic  head_done;

    x86enc_front u_front (
        .command   (command),
        .dest_kind (dest_kind),
        .dest_reg  (dest_reg),
        .dest_size (dest_size),
        .src_kind  (src_kind),
        .src_reg   (src_reg),
        .src_size  (src_size),
        .immediate (immediate),
        .desc      (front_desc)
    );

    x86enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (front_desc),
        .full     (full),
        .rd_en    (head_done),
        .rd_valid (head_valid),
        .rd_data  (head_desc)
    );

    x86enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_desc),
        .head_done  (head_done),
        .empty      (empty),
        .pop        (pop),
        .code_byte  (code_byte),
        .last_byte  (last_byte),
        .no_match   (no_match)
    );

endmodule

### hw/rtl/x86enc_front.sv
// front end: form table search and encoding of one instruction into a descriptor
// depends on x86enc_pkg
module x86enc_front
    import x86enc_pkg::*;
(
    input  logic [1:0]  command,
    input  logic [1:0]  dest_kind,
    input  logic [3:0]  dest_reg,
    input  logic [2:0]  dest_size,
    input  logic [1:0]  src_kind,
    input  logic [3:0]  src_reg,
    input  logic [2:0]  src_size,
    input  logic [63:0] immediate,
    output desc_t       desc
);

    logic [FORM_IDX_W-1:0] sel;
    logic                  found;
    form_t                 f;
    logic [2:0]            regf;
    logic [2:0]            rmf;
    logic                  rex_r;
    logic                  rex_b;
    logic [7:0]            opcode;
    logic [7:0]            rex;
    logic [1:0]            mode;
    logic                  has_imm;
    logic [2:0]            imm_last;

    // first matching form wins
    always_comb
    begin
        sel   = '0;
        found = 1'b0;
        for (int i = FORM_COUNT - 1; i >= 0; i--)
        begin
            if (FORMS[i].cmd == command && FORMS[i].kind0 == dest_kind &&
                FORMS[i].kind1 == src_kind && FORMS[i].size0 == dest_size &&
                FORMS[i].size1 == src_size)
            begin
                sel   = FORM_IDX_W'(i);
                found = 1'b1;
            end
        end
    end

    assign f = FORMS[sel];

    always_comb
    begin
        regf   = 3'd0;
        rmf    = 3'd0;
        rex_r  = 1'b0;
        rex_b  = 1'b0;
        opcode = f.opcode;
        unique case (f.ftype)
            T_PLAIN:
            begin
                if (f.has_modrm)
                begin
                    if (f.reg_is_dest)
                    begin
                        if (src_kind == K_REG || src_kind == K_MEM)
                        begin
                            rmf   = src_reg[2:0];
                            rex_b = src_reg[3];
                        end
                        if (dest_kind == K_REG)
                        begin
                            regf  = dest_reg[2:0];
                            rex_r = dest_reg[3];
                        end
                    end
                    else
                    begin
                        if (dest_kind == K_REG || dest_kind == K_MEM)
                        begin
                            rmf   = dest_reg[2:0];
                            rex_b = dest_reg[3];
                        end
                        if (src_kind == K_REG)
                        begin
                            regf  = src_reg[2:0];
                            rex_r = src_reg[3];
                        end
                    end
                end
            end
            T_EXT:
            begin
                regf  = f.ext;
                rmf   = dest_reg[2:0];
                rex_b = dest_reg[3];
            end
            T_PLUS:
            begin
                opcode = f.opcode | {5'd0, dest_reg[2:0]};
                rex_b  = dest_reg[3];
            end
            default:
            begin
                opcode = f.opcode;
            end
        endcase
    end

    assign rex  = (f.rex_w ? REX_W : 8'h00) | (rex_r ? REX_R : 8'h00) |
                  (rex_b ? REX_B : 8'h00);
    assign mode = (dest_kind == K_MEM || src_kind == K_MEM) ? MOD_INDIRECT : MOD_DIRECT;

    // little-endian immediate length from the source size
    always_comb
    begin
        has_imm  = (src_kind == K_IMM);
        imm_last = 3'd0;
        unique case (src_size)
            SZ_BYTE:  imm_last = 3'd0;
            SZ_WORD:  imm_last = 3'd1;
            SZ_DWORD: imm_last = 3'd3;
            SZ_QWORD: imm_last = 3'd7;
            default:  has_imm  = 1'b0;
        endcase
    end

    always_comb
    begin
        desc.imm      = immediate;
        desc.imm_last = imm_last;
        desc.modrm    = {mode, regf, rmf};
        desc.rex      = rex;
        if (found)
        begin
            desc.no_match  = 1'b0;
            desc.has_rex   = (rex != 8'h00);
            desc.opcode    = opcode;
            desc.has_modrm = f.has_modrm;
            desc.has_imm   = has_imm;
        end
        else
        begin
            desc.no_match  = 1'b1;
            desc.has_rex   = 1'b0;
            desc.opcode    = 8'h00;
            desc.has_modrm = 1'b0;
            desc.has_imm   = 1'b0;
        end
    end

endmodule

### hw/rtl/x86enc_queue.sv
// short descriptor queue between front end and back end
// depends on x86enc_pkg
module x86enc_queue
    import x86enc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  desc_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output logic  rd_valid,
    output desc_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    desc_t             store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_wr;
    logic              do_rd;

    assign full     = (count_reg == CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/x86enc_back.sv
// back end: byte sequencer with registered result stage
// depends on x86enc_pkg
module x86enc_back
    import x86enc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  desc_t      head,
    output logic       head_done,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] code_byte,
    output logic       last_byte,
    output logic       no_match
);

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     cur;
    phase_t     nxt;
    logic       busy_reg;
    logic       busy_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       nomatch_reg;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       advance;

    assign cur = busy_reg ? phase_reg : (head.has_rex ? PH_PREFIX : PH_OPCODE);

    always_comb
    begin
        cur_byte = head.opcode;
        cur_last = 1'b0;
        nxt      = PH_OPCODE;
        unique case (cur)
            PH_PREFIX:
            begin
                cur_byte = head.rex;
                nxt      = PH_OPCODE;
            end
            PH_OPCODE:
            begin
                cur_byte = head.opcode;
                if (head.has_modrm)
                begin
                    nxt = PH_MODRM;
                end
                else if (head.has_imm)
                begin
                    nxt = PH_IMM;
                end
                else
                begin
                    cur_last = 1'b1;
                end
            end
            PH_MODRM:
            begin
                cur_byte = head.modrm;
                nxt      = PH_IMM;
                cur_last = !head.has_imm;
            end
            PH_IMM:
            begin
                cur_byte = head.imm[{idx_reg, 3'b000} +: 8];
                nxt      = PH_IMM;
                cur_last = (idx_reg == head.imm_last);
            end
            default:
            begin
                cur_byte = head.opcode;
            end
        endcase
    end

    // result stage refills on the same edge as a transfer out
    assign advance   = head_valid && (!out_valid_reg || pop);
    assign head_done = advance && cur_last;

    always_comb
    begin
        phase_next     = phase_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (cur_last)
            begin
                busy_next = 1'b0;
                idx_next  = 3'd0;
            end
            else
            begin
                busy_next  = 1'b1;
                phase_next = nxt;
                if (cur == PH_IMM)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPCODE;
            busy_reg      <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg    <= cur_byte;
            last_reg    <= cur_last;
            nomatch_reg <= head.no_match;
        end
    end

    assign empty     = !out_valid_reg;
    assign code_byte = byte_reg;
    assign last_byte = last_reg;
    assign no_match  = nomatch_reg;

endmodule

### hw/rtl/x86enc_checker.sv
// port-level assertions for the encoder, bound to the top level
// depends on assert_macros.svh and x86_64_mov_add_sub_encoder
`include "assert_macros.svh"

module x86enc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] code_byte,
    input logic       last_byte,
    input logic       no_match
);

    // an unmatched instruction is a single zero byte
    `ASSERT_SAME(a_nomatch_single, clk, rst_n, !empty && no_match, last_byte && code_byte == 8'h00)

    // a waiting byte holds until its transfer
    `ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(code_byte) && $stable(last_byte))

    // the rest of an instruction follows with no gap and is never unmatched
    `ASSERT_NEXT(a_no_gap, clk, rst_n, !empty && pop && !last_byte, !empty && !no_match)

endmodule

bind x86_64_mov_add_sub_encoder x86enc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .code_byte (code_byte),
    .last_byte (last_byte),
    .no_match  (no_match)
);
